>>> design/fxc_pkg.sv
// fxc_pkg: shared types and constants for the fir filter with xor checksum
package fxc_pkg;

  localparam int TAP_COUNT = 16;
  localparam int TAP_W     = 4;
  localparam int SAMPLE_W  = 16;
  localparam int COEFF_W   = 4;
  localparam int PROD_W    = SAMPLE_W + COEFF_W + 1;
  localparam int ACC_W     = 23;
  localparam int SHIFT     = 7;
  localparam int CSUM_W    = 8;
  localparam int COUNT_W   = 16;

  // triangular coefficient 1..8,8..1 by tap position, oldest tap first
  function automatic logic [COEFF_W-1:0] tap_coeff(input logic [TAP_W-1:0] tap);
    logic [COEFF_W-1:0] c;
    if (tap[TAP_W-1] == 1'b0) begin
      c = COEFF_W'(tap) + COEFF_W'(1);
    end else begin
      c = COEFF_W'(TAP_COUNT - 1) - COEFF_W'(tap) + COEFF_W'(1);
    end
    return c;
  endfunction

  // commands from controller to datapath
  typedef struct packed {
    logic             load;
    logic             mac;
    logic [TAP_W-1:0] tap;
    logic             finish;
    logic             last;
  } fxc_cmd_t;

endpackage

>>> design/fxc_datapath.sv
// fxc_datapath: delay line, multiply-accumulate unit and result registers
module fxc_datapath (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  fxc_pkg::fxc_cmd_t                    cmd,
  input  logic signed [fxc_pkg::SAMPLE_W-1:0]  in_sample,
  output logic signed [fxc_pkg::SAMPLE_W-1:0]  out_filtered,
  output logic        [fxc_pkg::CSUM_W-1:0]    out_checksum,
  output logic                                 out_block_end
);
  import fxc_pkg::*;

  logic signed [SAMPLE_W-1:0] window_r [TAP_COUNT];
  logic signed [ACC_W-1:0]    acc_r;
  logic signed [ACC_W-1:0]    acc_nxt;
  logic signed [PROD_W-1:0]   prod;
  logic        [CSUM_W-1:0]   xor_r;
  logic        [SAMPLE_W-1:0] res;
  logic        [CSUM_W-1:0]   csum_nxt;

  // one tap product, sign extended into the accumulator
  always_comb begin
    prod    = $signed({1'b0, tap_coeff(cmd.tap)}) * window_r[cmd.tap];
    acc_nxt = acc_r + {{(ACC_W - PROD_W){prod[PROD_W-1]}}, prod};
  end

  // floor shift of the sum, low byte folded into the checksum
  assign res      = acc_r[SHIFT +: SAMPLE_W];
  assign csum_nxt = xor_r ^ res[CSUM_W-1:0];

  // delay line, index 0 holds the oldest sample
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int i = 0; i < TAP_COUNT - 1; i++) begin
        window_r[i] <= window_r[i + 1];
      end
      window_r[TAP_COUNT - 1] <= in_sample;
    end
  end

  // accumulator
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      acc_r <= '0;
    end else if (cmd.mac) begin
      acc_r <= acc_nxt;
    end
  end

  // running checksum, cleared at reset and at the end of a block
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xor_r <= '0;
    end else if (cmd.finish) begin
      xor_r <= cmd.last ? '0 : csum_nxt;
    end
  end

  // result word registers
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_filtered  <= $signed(res);
      out_checksum  <= csum_nxt;
      out_block_end <= cmd.last;
    end
  end

endmodule

>>> design/fxc_ctrl.sv
// fxc_ctrl: sequencer for fill, tap iteration, block counting and output valid
module fxc_ctrl #(
  parameter int BLOCK_OUTPUTS = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output fxc_pkg::fxc_cmd_t cmd
);
  import fxc_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MAC,
    S_DONE
  } state_t;

  localparam logic [TAP_W-1:0]   FULL_FILL  = TAP_W'(TAP_COUNT - 1);
  localparam logic [TAP_W-1:0]   LAST_TAP   = TAP_W'(TAP_COUNT - 1);
  localparam logic [COUNT_W-1:0] LAST_COUNT = COUNT_W'(BLOCK_OUTPUTS - 1);

  state_t               state_r, state_nxt;
  logic [TAP_W-1:0]     tap_r, tap_nxt;
  logic [TAP_W-1:0]     fill_r, fill_nxt;
  logic [COUNT_W-1:0]   count_r, count_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_free;
  logic                 last;

  assign out_free  = !out_valid_r || !out_stall;
  assign last      = (count_r == LAST_COUNT);
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  // next state and datapath commands
  always_comb begin
    state_nxt     = state_r;
    tap_nxt       = tap_r;
    fill_nxt      = fill_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    cmd.tap       = tap_r;
    cmd.last      = last;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (fill_r != FULL_FILL) begin
            fill_nxt = fill_r + TAP_W'(1);
          end else begin
            tap_nxt   = '0;
            state_nxt = S_MAC;
          end
        end
      end
      S_MAC: begin
        cmd.mac = 1'b1;
        tap_nxt = tap_r + TAP_W'(1);
        if (tap_r == LAST_TAP) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
          if (last) begin
            count_nxt = '0;
            fill_nxt  = '0;
          end else begin
            count_nxt = count_r + COUNT_W'(1);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tap_r       <= '0;
      fill_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tap_r       <= tap_nxt;
      fill_r      <= fill_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> design/fir_filter_with_xor_checksum_top.sv
// fir_filter_with_xor_checksum_top: 16-tap triangular fir filter with block checksum
//
//   channel  direction  handshake           payload
//   in       input      in_valid/in_stall   in_sample (s16)
//   out      output     out_valid/out_stall out_filtered (s16), out_checksum (u8),
//                                           out_block_end (u1)
//
// a word that only fills the delay line is just shifted in; a word that yields a result
// is shifted in, then stepped through all taps of the single tap multiply-accumulate
// unit, and the result is then loaded into the output register.
// the result waits in the output register; the next word is taken while it waits,
// and a new result is held back until the register is free.
// rst_n is synchronous; it clears the sequencer, counters, checksum and output valid.
module fir_filter_with_xor_checksum_top #(
  parameter int BLOCK_OUTPUTS = 64
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [fxc_pkg::SAMPLE_W-1:0]  in_sample,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [fxc_pkg::SAMPLE_W-1:0]  out_filtered,
  output logic        [fxc_pkg::CSUM_W-1:0]    out_checksum,
  output logic                                 out_block_end
);
  import fxc_pkg::*;

  fxc_cmd_t cmd;

  // controller
  fxc_ctrl #(
    .BLOCK_OUTPUTS (BLOCK_OUTPUTS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // datapath
  fxc_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .in_sample     (in_sample),
    .out_filtered  (out_filtered),
    .out_checksum  (out_checksum),
    .out_block_end (out_block_end)
  );

endmodule

>>> design/fxc_checker.sv
// fxc_checker: port-level assertions for the fir filter top, with bind
module fxc_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_valid,
  input logic                                 in_stall,
  input logic                                 out_valid,
  input logic                                 out_stall,
  input logic signed [fxc_pkg::SAMPLE_W-1:0]  out_filtered,
  input logic        [fxc_pkg::CSUM_W-1:0]    out_checksum,
  input logic                                 out_block_end
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_filtered)
      && $stable(out_checksum) && $stable(out_block_end))
    else $error("result word changed while stalled");

  // a new result only appears after the input side was busy computing
  a_rise_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a compute phase");

  // reset empties the output register and releases the input side
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("output valid or input stall set after reset");

  // no result word follows directly on an input word being taken
  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> !$rose(out_valid))
    else $error("result appeared one cycle after input word");

endmodule

bind fir_filter_with_xor_checksum_top fxc_checker u_fxc_checker (.*);
